@@ rtl/core/framed_packet_parser_crc32_macros.svh @@
// assertion macros for the framed packet parser
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef FRAMED_PACKET_PARSER_CRC32_MACROS_SVH
`define FRAMED_PACKET_PARSER_CRC32_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FPPC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fppc assertion failed");

`define FPPC_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("fppc assertion failed during or after reset");

`else

`define FPPC_ASSERT(name, prop)

`define FPPC_ASSERT_ALWAYS(name, prop)

`endif

`endif

@@ rtl/core/fppc_pkg.sv @@
// shared types, constants and the byte-wide crc-32 update for the frame parser
// no dependencies
package fppc_pkg;

  localparam int unsigned FrameLen = 15;
  localparam int unsigned CountMax = 16;
  localparam int unsigned CountW   = 5;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam int unsigned OutDataW = 104;
  localparam int unsigned OutUserW = 3;

  // register indexes on the cfg channel
  localparam logic CfgStart = 1'b0;
  localparam logic CfgEnd   = 1'b1;

  typedef enum logic [2:0] {
    OUT_OK        = 3'd0,
    OUT_BAD_LEN   = 3'd1,
    OUT_BAD_START = 3'd2,
    OUT_BAD_END   = 3'd3,
    OUT_BAD_CRC   = 3'd4
  } outcome_e;

  typedef logic [CountW-1:0] count_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/framed_packet_parser_crc32.sv @@
// framed packet parser with crc-32 check, one byte word in, one result word per frame
// depends on fppc_pkg and framed_packet_parser_crc32_macros.svh
//
// channel   dir  handshake               payload
// s_axis    in   tvalid / tready         tdata: data_byte, tlast: last_byte
// m_axis    out  tvalid / tready         tuser: outcome, tdata: frame fields
// cfg       in   cfg_valid / cfg_ready   cfg_index: register, cfg_data: value
//
// one byte word is taken per cycle while s_axis_tready is high; the crc update is a combinational byte step
// a result appears in the output register the cycle after the flagged byte
// s_axis_tready drops only while a result waits and m_axis_tready is low
// reset clears the count, start flag, markers and the output valid and loads crc with CrcInit; cfg is always ready
`include "framed_packet_parser_crc32_macros.svh"

module framed_packet_parser_crc32 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // data_byte
  input  logic                          s_axis_tlast,  // last_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status_byte, request_id, response_flag, kind, payload_value, received_crc
  output logic [fppc_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [fppc_pkg::OutUserW-1:0] m_axis_tuser,  // outcome
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import fppc_pkg::*;

  logic        in_acc;
  logic        out_acc;
  count_t      count_q, count_d;
  logic [31:0] crc_q, crc_d;
  logic        start_good_q, start_good_d;
  logic [7:0]  start_marker_q, end_marker_q;
  logic [7:0]  status_q, status_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  flag_q, flag_d;
  logic [7:0]  kind_q, kind_d;
  logic [31:0] value_q, value_d;
  logic [31:0] rcrc_q, rcrc_d;
  logic        out_valid_q;
  outcome_e    outcome;
  logic        fields_ok;
  logic        out_failed;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [OutUserW-1:0] out_user_q;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = out_valid_q && m_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= 8'd0;
      end_marker_q   <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgStart: start_marker_q <= cfg_data_i;
        CfgEnd:   end_marker_q   <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // frame capture
  always_comb begin
    count_d      = count_q;
    crc_d        = crc_q;
    start_good_d = start_good_q;
    status_d     = status_q;
    id_d         = id_q;
    flag_d       = flag_q;
    kind_d       = kind_q;
    value_d      = value_q;
    rcrc_d       = rcrc_q;
    if (count_q >= CountW'(1) && count_q <= CountW'(9)) begin
      crc_d = crc_byte(crc_q, s_axis_tdata);
    end
    case (count_q)
      5'd0:    start_good_d = (s_axis_tdata == start_marker_q);
      5'd1:    status_d = s_axis_tdata;
      5'd2:    id_d[7:0] = s_axis_tdata;
      5'd3:    id_d[15:8] = s_axis_tdata;
      5'd4:    flag_d = s_axis_tdata;
      5'd5:    kind_d = s_axis_tdata;
      5'd6:    value_d[7:0] = s_axis_tdata;
      5'd7:    value_d[15:8] = s_axis_tdata;
      5'd8:    value_d[23:16] = s_axis_tdata;
      5'd9:    value_d[31:24] = s_axis_tdata;
      5'd10:   rcrc_d[7:0] = s_axis_tdata;
      5'd11:   rcrc_d[15:8] = s_axis_tdata;
      5'd12:   rcrc_d[23:16] = s_axis_tdata;
      5'd13:   rcrc_d[31:24] = s_axis_tdata;
      default: ;
    endcase
    if (count_q < CountW'(CountMax)) begin
      count_d = count_q + CountW'(1);
    end
    if (s_axis_tlast) begin
      count_d      = '0;
      crc_d        = CrcInit;
      start_good_d = 1'b0;
    end
  end

  // outcome of the flagged byte
  always_comb begin
    if (count_q != CountW'(FrameLen - 1)) begin
      outcome = OUT_BAD_LEN;
    end else if (!start_good_q) begin
      outcome = OUT_BAD_START;
    end else if (s_axis_tdata != end_marker_q) begin
      outcome = OUT_BAD_END;
    end else if (~crc_q != rcrc_q) begin
      outcome = OUT_BAD_CRC;
    end else begin
      outcome = OUT_OK;
    end
    fields_ok  = (outcome == OUT_OK) || (outcome == OUT_BAD_CRC);
    out_data_d = fields_ok ? {rcrc_q, value_q, kind_q, flag_q, id_q, status_q}
                           : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      crc_q        <= CrcInit;
      start_good_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q      <= count_d;
        crc_q        <= crc_d;
        start_good_q <= start_good_d;
      end
      if (in_acc && s_axis_tlast) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      id_q     <= id_d;
      flag_q   <= flag_d;
      kind_q   <= kind_d;
      value_q  <= value_d;
      rcrc_q   <= rcrc_d;
    end
    if (in_acc && s_axis_tlast) begin
      out_data_q <= out_data_d;
      out_user_q <= outcome;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  assign out_failed = (m_axis_tuser == OUT_BAD_LEN) || (m_axis_tuser == OUT_BAD_START) ||
                      (m_axis_tuser == OUT_BAD_END);

  `FPPC_ASSERT_ALWAYS(a_count_saturates, count_q <= CountW'(CountMax))
  `FPPC_ASSERT(a_frame_clears, in_acc && s_axis_tlast |=> count_q == '0 && crc_q == CrcInit)
  `FPPC_ASSERT(a_result_follows, in_acc && s_axis_tlast |=> m_axis_tvalid)
  `FPPC_ASSERT(a_failed_fields_zero, m_axis_tvalid && out_failed |-> m_axis_tdata == '0)

endmodule
